@@ src/scfp_pkg.sv @@
// ----------------------------------------------------------------------------
// scfp_pkg
// Shared types and constants of the sum-checksum frame parser.
// ----------------------------------------------------------------------------
package scfp_pkg;

    localparam int unsigned IdxW      = 9;
    localparam int unsigned QueueDepth = 4;
    localparam int unsigned PtrW      = $clog2(QueueDepth);
    localparam int unsigned CntW      = $clog2(QueueDepth + 1);
    localparam int unsigned OutDataW  = 72;

    localparam logic [IdxW-1:0] IdxMax    = 9'd511;
    localparam logic [IdxW-1:0] IdxLen    = 9'd8;
    localparam logic [IdxW-1:0] IdxFirstPl = 9'd9;
    localparam logic [IdxW-1:0] MinFrame  = 9'd11;

    localparam logic [2:0] StatusOk      = 3'd0;
    localparam logic [2:0] StatusShort   = 3'd1;
    localparam logic [2:0] StatusSumErr  = 3'd2;
    localparam logic [2:0] StatusBadSync = 3'd3;
    localparam logic [2:0] StatusTooLong = 3'd4;

    localparam logic KindPayload = 1'b0;
    localparam logic KindVerdict = 1'b1;

    localparam logic CfgSyncWord = 1'b0;
    localparam logic CfgMaxLen   = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [2:0]  status;
        logic [15:0] source_addr;
        logic [15:0] dest_addr;
        logic [15:0] command;
        logic [7:0]  payload_length;
        logic        run_end;
    } t_result;

    // up to two results per input word, first slot always used first
    typedef struct packed {
        logic    push0;
        logic    push1;
        t_result res0;
        t_result res1;
    } t_push;

endpackage

@@ src/scfp_parser.sv @@
// ----------------------------------------------------------------------------
// scfp_parser
// Input register, frame state and per-byte result generation.
// ----------------------------------------------------------------------------
module scfp_parser
    import scfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    input  logic [15:0] i_sync_word,
    input  logic [7:0]  i_max_len,
    input  logic        i_space,
    output t_push       o_push
);

    logic            r_valid;
    logic [7:0]      r_byte;
    logic            r_last;

    logic [IdxW-1:0] r_idx;
    logic [15:0]     r_sum;
    logic [7:0]      r_prev;
    logic [15:0]     r_sync;
    logic [15:0]     r_src;
    logic [15:0]     r_dst;
    logic [15:0]     r_cmd;
    logic [7:0]      r_len;

    logic [15:0]     n_sync;
    logic [15:0]     n_src;
    logic [15:0]     n_dst;
    logic [15:0]     n_cmd;
    logic [7:0]      n_len;
    logic            advance;
    logic            load;
    logic            pay;
    logic [IdxW:0]   pay_end;
    logic [15:0]     calc_sum;
    logic [15:0]     recv_sum;
    logic [2:0]      status;
    t_result         pay_res;
    t_result         ver_res;

    assign advance = r_valid && i_space;
    assign o_ready = !r_valid || advance;
    assign load    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (load) begin
            r_byte <= i_byte;
            r_last <= i_last;
        end
    end

    // header capture, big-endian words shift in a byte at a time
    always_comb begin
        n_sync = r_sync;
        n_src  = r_src;
        n_dst  = r_dst;
        n_cmd  = r_cmd;
        n_len  = r_len;
        priority if (r_idx < 9'd2) begin
            n_sync = {r_sync[7:0], r_byte};
        end else if (r_idx < 9'd4) begin
            n_src = {r_src[7:0], r_byte};
        end else if (r_idx < 9'd6) begin
            n_dst = {r_dst[7:0], r_byte};
        end else if (r_idx < IdxLen) begin
            n_cmd = {r_cmd[7:0], r_byte};
        end else if (r_idx == IdxLen) begin
            n_len = r_byte;
        end else begin
            n_len = r_len;
        end
    end

    assign pay_end  = {1'b0, IdxLen} + {2'b00, n_len};
    assign pay      = (r_idx >= IdxFirstPl) && ({1'b0, r_idx} <= pay_end)
                      && (n_len <= i_max_len);
    assign calc_sum = r_sum - {8'd0, r_prev};
    assign recv_sum = {r_prev, r_byte};

    always_comb begin
        priority if ({1'b0, r_idx} + 10'd1 < {1'b0, MinFrame}) begin
            status = StatusShort;
        end else if (calc_sum != recv_sum) begin
            status = StatusSumErr;
        end else if (n_sync != i_sync_word) begin
            status = StatusBadSync;
        end else if (n_len > i_max_len) begin
            status = StatusTooLong;
        end else begin
            status = StatusOk;
        end
    end

    always_comb begin
        pay_res              = '0;
        pay_res.kind         = KindPayload;
        pay_res.payload_byte = r_byte;

        ver_res          = '0;
        ver_res.kind     = KindVerdict;
        ver_res.status   = status;
        ver_res.run_end  = 1'b1;
        if (status == StatusOk) begin
            ver_res.source_addr    = n_src;
            ver_res.dest_addr      = n_dst;
            ver_res.command        = n_cmd;
            ver_res.payload_length = n_len;
        end

        o_push.push0 = advance && (pay || r_last);
        o_push.push1 = advance && pay && r_last;
        o_push.res0  = pay ? pay_res : ver_res;
        o_push.res1  = ver_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_sum  <= '0;
            r_prev <= '0;
            r_sync <= '0;
            r_src  <= '0;
            r_dst  <= '0;
            r_cmd  <= '0;
            r_len  <= '0;
        end else if (advance) begin
            if (r_last) begin
                r_idx  <= '0;
                r_sum  <= '0;
                r_prev <= '0;
                r_sync <= '0;
                r_src  <= '0;
                r_dst  <= '0;
                r_cmd  <= '0;
                r_len  <= '0;
            end else begin
                r_sum  <= r_sum + {8'd0, r_byte};
                r_prev <= r_byte;
                r_sync <= n_sync;
                r_src  <= n_src;
                r_dst  <= n_dst;
                r_cmd  <= n_cmd;
                r_len  <= n_len;
                if (r_idx != IdxMax) begin
                    r_idx <= r_idx + 9'd1;
                end
            end
        end
    end

endmodule

@@ src/scfp_out_fifo.sv @@
// ----------------------------------------------------------------------------
// scfp_out_fifo
// Small result queue taking up to two results a cycle, giving one.
// ----------------------------------------------------------------------------
module scfp_out_fifo
    import scfp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    t_result         r_mem [QueueDepth];
    logic [PtrW-1:0] r_wr;
    logic [PtrW-1:0] r_rd;
    logic [CntW-1:0] r_cnt;

    logic            pop;
    logic [CntW-1:0] n_cnt;
    logic [PtrW-1:0] wr_next;

    assign o_valid = (r_cnt != '0);
    assign o_res   = r_mem[r_rd];
    assign pop     = o_valid && i_ready;
    // room for a full pair of results
    assign o_space = (r_cnt <= CntW'(QueueDepth - 2));
    assign wr_next = r_wr + PtrW'(1);

    always_comb begin
        n_cnt = r_cnt + CntW'(i_push.push0) + CntW'(i_push.push1) - CntW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.push1) begin
            r_mem[wr_next] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (pop) begin
                r_rd <= r_rd + PtrW'(1);
            end
            if (i_push.push1) begin
                r_wr <= r_wr + PtrW'(2);
            end else if (i_push.push0) begin
                r_wr <= wr_next;
            end
        end
    end

endmodule

@@ src/sum_checksum_frame_parser.sv @@
// ----------------------------------------------------------------------------
// sum_checksum_frame_parser
// Byte-stream deframer: header capture, payload pass-through, sum-16 check.
// ----------------------------------------------------------------------------
// usage:
//   slave side takes one frame byte per word, tlast on the frame's final byte.
//   master side gives payload words (tuser 0) for bytes at offsets 9 to
//   8+length if length <= max_payload_len, and one verdict word (tuser 1,
//   tlast 1) per frame carrying the status and, when ok, the header fields.
//   a final byte that is also a payload byte yields its payload word first,
//   then the verdict.
//   throughput is one byte per cycle while the result queue has room; an
//   accepted byte passes the input register, then the four-entry result
//   queue, on its way to the master side. the queue only drains at one word
//   a cycle, so the verdict word that follows a payload word is absorbed
//   by the queue. when the receiver stalls the queue fills and s_tready
//   drops once fewer than two entries are free; nothing is lost.
//   reset empties the queue, clears the frame state, sets sync_word to 0 and
//   max_payload_len to 255.
//   config writes are taken whenever i_cfg_we is high; write them between
//   frames only.
// ----------------------------------------------------------------------------
module sum_checksum_frame_parser
    import scfp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // slave side
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // data_byte[7:0]
    input  logic                s_tlast,   // end_of_frame
    // master side
    output logic                m_tvalid,
    input  logic                m_tready,
    // payload_byte[7:0], status[10:8], source_addr[26:11], dest_addr[42:27],
    // command[58:43], payload_length[66:59], zero[71:67]
    output logic [OutDataW-1:0] m_tdata,
    output logic                m_tuser,   // kind
    output logic                m_tlast,   // run_end
    // configuration
    input  logic                i_cfg_we,
    input  logic                i_cfg_addr,
    input  logic [15:0]         i_cfg_wdata
);

    logic [15:0] r_sync_word;
    logic [7:0]  r_max_len;
    logic        space;
    t_push       push;
    t_result     res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_word <= 16'd0;
            r_max_len   <= 8'd255;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CfgSyncWord: r_sync_word <= i_cfg_wdata;
                CfgMaxLen:   r_max_len   <= i_cfg_wdata[7:0];
                default:     r_max_len   <= r_max_len;
            endcase
        end
    end

    scfp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_tvalid),
        .o_ready     (s_tready),
        .i_byte      (s_tdata),
        .i_last      (s_tlast),
        .i_sync_word (r_sync_word),
        .i_max_len   (r_max_len),
        .i_space     (space),
        .o_push      (push)
    );

    scfp_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (space),
        .o_valid (m_tvalid),
        .i_ready (m_tready),
        .o_res   (res)
    );

    assign m_tdata = {5'd0, res.payload_length, res.command, res.dest_addr,
                      res.source_addr, res.status, res.payload_byte};
    assign m_tuser = res.kind;
    assign m_tlast = res.run_end;

endmodule
